@@ hw/rtl/program_header_checker_top_macros.svh @@
// Assertion macros used by the program header checker top level.
`ifndef PROGRAM_HEADER_CHECKER_TOP_MACROS_SVH
`define PROGRAM_HEADER_CHECKER_TOP_MACROS_SVH

// Checked on every clock edge, idle while reset is held.
`define PCHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, including reset cycles.
`define PCHK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/pchk_pkg.sv @@
// Types and constants of the program header checker.
`timescale 1ns / 1ps

package pchk_pkg;

  localparam int ADDR_BITS  = 64;                 // header word width, 32 to 64
  localparam int WORD_BITS  = 64;
  localparam int TYPE_BITS  = 32;
  localparam int STEP_BITS  = 4;                  // remainder bits resolved per stage
  localparam int DIV_STAGES = (ADDR_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_BITS   = DIV_STAGES * STEP_BITS;

  // input item layout in s_tdata
  localparam int TYPE_LSB  = 0;
  localparam int OFF_LSB   = TYPE_LSB + TYPE_BITS;
  localparam int VADDR_LSB = OFF_LSB + WORD_BITS;
  localparam int PADDR_LSB = VADDR_LSB + WORD_BITS;
  localparam int FSZ_LSB   = PADDR_LSB + WORD_BITS;
  localparam int MSZ_LSB   = FSZ_LSB + WORD_BITS;
  localparam int ALIGN_LSB = MSZ_LSB + WORD_BITS;
  localparam int IN_BITS   = ALIGN_LSB + WORD_BITS;
  localparam int OUT_BITS  = 8;

  localparam logic [TYPE_BITS-1:0] TYPE_LOADABLE = TYPE_BITS'(1);

  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_FILE_RANGE = 3'd1;
  localparam logic [2:0] FAULT_ADDR_OVF   = 3'd2;
  localparam logic [2:0] FAULT_LOAD_SIZE  = 3'd3;
  localparam logic [2:0] FAULT_ALIGN      = 3'd4;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHECKS_EN = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILE_SIZE = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [2:0] code;         // fault from the range and size checks
    logic       check_align;  // remainder decides the alignment fault
  } pchk_side_t;

endpackage

@@ hw/rtl/program_header_checker_top.sv @@
// Top level of the program header checker.
`timescale 1ns / 1ps
`include "program_header_checker_top_macros.svh"

// Program header checker: classifies one program header entry per item.
// s_tdata carries type, offset, vaddr, paddr, file size, memory size and
// alignment; m_tdata returns entry_valid and the first fault code.
// The cfg channel writes checks_enabled (index 0) and file_size (index 1);
// cfg_ready is always high and writes take effect at once.
// Pipeline: input register, range/size check stage, ADDR_BITS/4 remainder
// stages (|offset - vaddr| mod alignment, four bits per stage), output
// register. Throughput is one item per clock while m_tready stays high;
// every stage holds a valid bit and takes a new item when it is empty
// or its successor moves on.
// When the receiver stalls, bubbles in the pipeline still fill, so s_tready
// drops only once every stage holds an item.
// Reset empties the pipeline, enables checking and clears file_size.

module program_header_checker_top (
  input  logic                               clk,
  input  logic                               rst,
  // segment_type, file_offset, virtual_address, physical_address,
  // size_in_file, size_in_memory, alignment (lowest bit first)
  input  logic [pchk_pkg::IN_BITS-1:0]       s_tdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // entry_valid, fault_code, zero fill (lowest bit first)
  output logic [pchk_pkg::OUT_BITS-1:0]      m_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pchk_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pchk_pkg::WORD_BITS-1:0]     cfg_data
);
  import pchk_pkg::*;

  logic                 checks_en;
  logic [WORD_BITS-1:0] file_size;

  logic                 v0;
  logic                 ready0;
  logic [TYPE_BITS-1:0] type0;
  logic [ADDR_BITS-1:0] off0, va0, pa0, fsz0, msz0, al0;

  logic [ADDR_BITS:0]   sum_f, sum_v;
  logic [ADDR_BITS-1:0] diff;
  pchk_side_t           side_next;
  logic                 ready1;
  logic                 out_ready;
  logic [2:0]           code_final;

  logic                 c_valid [DIV_STAGES+1];
  logic [DIV_STAGES:0]  c_ready;
  logic [ADDR_BITS-1:0] c_rem [DIV_STAGES+1];
  logic [DIV_BITS-1:0]  c_dvd [DIV_STAGES+1];
  logic [ADDR_BITS-1:0] c_div [DIV_STAGES+1];
  pchk_side_t           c_side [DIV_STAGES+1];

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      checks_en <= 1'b1;
      file_size <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHECKS_EN: checks_en <= cfg_data[0];
        CFG_FILE_SIZE: file_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, words cut to the header class width
  assign ready0   = !v0 || ready1;
  assign s_tready = ready0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ready0) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready0 && s_tvalid) begin
      type0 <= s_tdata[TYPE_LSB +: TYPE_BITS];
      off0  <= s_tdata[OFF_LSB +: ADDR_BITS];
      va0   <= s_tdata[VADDR_LSB +: ADDR_BITS];
      pa0   <= s_tdata[PADDR_LSB +: ADDR_BITS];
      fsz0  <= s_tdata[FSZ_LSB +: ADDR_BITS];
      msz0  <= s_tdata[MSZ_LSB +: ADDR_BITS];
      al0   <= s_tdata[ALIGN_LSB +: ADDR_BITS];
    end
  end

  // range and size checks; alignment becomes a divisibility test of |off - vaddr|
  assign sum_f = {1'b0, off0} + {1'b0, fsz0};
  assign sum_v = {1'b0, va0} + {1'b0, msz0};
  assign diff  = (off0 >= va0) ? (off0 - va0) : (va0 - off0);

  always_comb begin
    side_next.code        = FAULT_NONE;
    side_next.check_align = 1'b0;
    if (!checks_en || (off0 == '0 && va0 == '0 && pa0 == '0 && fsz0 == '0 && msz0 == '0)) begin
      side_next.code = FAULT_NONE;
    end else if (sum_f[ADDR_BITS] || (WORD_BITS'(sum_f[ADDR_BITS-1:0]) > file_size)) begin
      side_next.code = FAULT_FILE_RANGE;
    end else if (sum_v[ADDR_BITS]) begin
      side_next.code = FAULT_ADDR_OVF;
    end else if (type0 == TYPE_LOADABLE && (msz0 == '0 || fsz0 > msz0)) begin
      side_next.code = FAULT_LOAD_SIZE;
    end else begin
      side_next.check_align = (al0 != '0);
    end
  end

  assign ready1 = !c_valid[0] || c_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (ready1) begin
      c_valid[0] <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && v0) begin
      c_rem[0]  <= '0;
      c_dvd[0]  <= DIV_BITS'(diff);
      c_div[0]  <= al0;
      c_side[0] <= side_next;
    end
  end

  // remainder pipeline
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_rem
    pchk_rem_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_rem    (c_rem[g]),
      .in_dvd    (c_dvd[g]),
      .in_div    (c_div[g]),
      .in_side   (c_side[g]),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_rem   (c_rem[g+1]),
      .out_dvd   (c_dvd[g+1]),
      .out_div   (c_div[g+1]),
      .out_side  (c_side[g+1])
    );
  end

  // output register
  assign out_ready           = !m_tvalid || m_tready;
  assign c_ready[DIV_STAGES] = out_ready;

  always_comb begin
    code_final = c_side[DIV_STAGES].code;
    if (c_side[DIV_STAGES].code == FAULT_NONE && c_side[DIV_STAGES].check_align &&
        c_rem[DIV_STAGES] != '0) begin
      code_final = FAULT_ALIGN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= c_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && c_valid[DIV_STAGES]) begin
      m_tdata <= {4'b0000, code_final, (code_final == FAULT_NONE)};
    end
  end

  `PCHK_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid right after reset")
  `PCHK_ASSERT(a_stall_full, !s_tready |-> (m_tvalid && !m_tready), "input stalled while output free")
  `PCHK_ASSERT(a_align_after_fault, (c_valid[0] && c_side[0].code != FAULT_NONE) |-> !c_side[0].check_align, "alignment test armed after earlier fault")

endmodule

@@ hw/rtl/pchk_rem_stage.sv @@
// One pipeline stage of the remainder unit: STEP_BITS restoring steps.
`timescale 1ns / 1ps

module pchk_rem_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pchk_pkg::ADDR_BITS-1:0]     in_rem,
  input  logic [pchk_pkg::DIV_BITS-1:0]      in_dvd,
  input  logic [pchk_pkg::ADDR_BITS-1:0]     in_div,
  input  pchk_pkg::pchk_side_t               in_side,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pchk_pkg::ADDR_BITS-1:0]     out_rem,
  output logic [pchk_pkg::DIV_BITS-1:0]      out_dvd,
  output logic [pchk_pkg::ADDR_BITS-1:0]     out_div,
  output pchk_pkg::pchk_side_t               out_side
);
  import pchk_pkg::*;

  logic [ADDR_BITS:0]   trial;
  logic [ADDR_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0]  dvd_next;

  assign in_ready = !out_valid || out_ready;

  // remainder stays below the divisor, so one compare-subtract per bit
  always_comb begin
    rem_next = in_rem;
    dvd_next = in_dvd;
    trial    = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial    = {rem_next, dvd_next[DIV_BITS-1]};
      dvd_next = {dvd_next[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, in_div}) begin
        trial = trial - {1'b0, in_div};
      end
      rem_next = trial[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rem  <= rem_next;
      out_dvd  <= dvd_next;
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule
